### rtl/lcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared constants for the unit cube line clipper.
// ----------------------------------------------------------------------------
package lcc_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS       = 16;
  localparam int T_BITS          = 32;
endpackage
`default_nettype wire

### rtl/line_clip_unit_cube.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_clip_unit_cube
// Liang-Barsky clipping of a 3D segment against the cube [-1, 1]^3.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid / in_stall) carries one segment per beat,
// start and end points in signed Q16.16. The output channel (out_valid /
// out_stall) returns one beat per segment: visible flag and clipped points.
// A new segment is taken every cycle while in_stall is low. The path is:
// an entry register, the six bit-per-stage divider pipelines (one per cube
// face, T_BITS stages) that run in parallel, two face folding stages, a
// multiply stage and an add/saturate output stage.
// The whole pipeline advances as one: when the receiver stalls with a valid
// result at the output, every stage holds and in_stall is raised, so no beat
// is lost or repeated. Bubbles inside the pipe are not squeezed out; the
// pipe holds only while the output stage is full and stalled. Synchronous
// active-low reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module line_clip_unit_cube
  import lcc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_z,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_visible,
  output logic signed [COORD_WIDTH-1:0]      out_clip_start_x,
  output logic signed [COORD_WIDTH-1:0]      out_clip_start_y,
  output logic signed [COORD_WIDTH-1:0]      out_clip_start_z,
  output logic signed [COORD_WIDTH-1:0]      out_clip_end_x,
  output logic signed [COORD_WIDTH-1:0]      out_clip_end_y,
  output logic signed [COORD_WIDTH-1:0]      out_clip_end_z
);
  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 2;           // |p|, |q| magnitudes
  localparam int NF = 6;
  localparam logic [T_BITS:0] T_ONE = {1'b1, {T_BITS{1'b0}}};

  // Face codes: cat 0 no effect, 1 reject, 2 divide.
  typedef enum logic [1:0] {C_NONE, C_REJ, C_DIV} cat_t;
  typedef struct packed {
    cat_t cat;
    logic one;     // quotient is exactly 1
    logic enter;   // p > 0
  } face_t;

  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // ---------------- stage 0: differences and face tests --------------------
  logic signed [CW:0] s_w [3];
  logic signed [CW:0] e_w [3];
  assign s_w[0] = {in_start_x[CW-1], in_start_x};
  assign s_w[1] = {in_start_y[CW-1], in_start_y};
  assign s_w[2] = {in_start_z[CW-1], in_start_z};
  assign e_w[0] = {in_end_x[CW-1], in_end_x};
  assign e_w[1] = {in_end_y[CW-1], in_end_y};
  assign e_w[2] = {in_end_z[CW-1], in_end_z};

  localparam logic signed [CW+1:0] ONE_Q = (CW+2)'(1) <<< FRAC_BITS;

  logic            v0_r;
  logic signed [CW:0]   s0_r [3];
  logic signed [CW:0]   e0_r [3];
  logic signed [CW+1:0] d0_r [3];
  face_t           f0_r [NF];
  logic [DW-1:0]   n0_r [NF];
  logic [DW-1:0]   dn0_r [NF];

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_valid;
  end

  for (genvar f = 0; f < NF; f++) begin : g_face
    localparam int AX = f / 2;
    logic signed [CW+1:0] d, p, q, b;
    logic [DW-1:0] pa, qa, ba;
    face_t fc;
    always_comb begin
      d  = {e_w[AX][CW], e_w[AX]} - {s_w[AX][CW], s_w[AX]};
      p  = (f % 2 == 0) ? d : -d;
      q  = (f % 2 == 0) ? -ONE_Q - {s_w[AX][CW], s_w[AX]}
                        : {s_w[AX][CW], s_w[AX]} - ONE_Q;
      b  = -q;
      pa = DW'(p[CW+1] ? -p : p);
      qa = DW'(q);
      ba = DW'(b);
      fc = '{cat: C_NONE, one: 1'b0, enter: 1'b0};
      if (p > 0) begin
        fc.enter = 1'b1;
        if (q <= 0)      fc.cat = C_NONE;
        else if (q > p)  fc.cat = C_REJ;
        else begin fc.cat = C_DIV; fc.one = (q == p); end
      end else if (p < 0) begin
        if (b < 0)                 fc.cat = C_REJ;
        else if (b > -p)           fc.cat = C_NONE;
        else begin fc.cat = C_DIV; fc.one = (b == -p); end
      end else if (q > 0) begin
        fc.cat = C_REJ;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        f0_r[f]  <= fc;
        n0_r[f]  <= fc.enter ? qa : ba;
        dn0_r[f] <= pa;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        s0_r[a] <= s_w[a];
        e0_r[a] <= e_w[a];
        d0_r[a] <= {e_w[a][CW], e_w[a]} - {s_w[a][CW], s_w[a]};
      end
    end
  end

  // ---------------- divider pipelines --------------------------------------
  localparam int FW = $bits(face_t);
  logic [31:0]  tq [NF];
  face_t        f1 [NF];
  logic [FW-1:0] fside [NF];
  for (genvar f = 0; f < NF; f++) begin : g_div
    lcc_div #(.DW(DW), .SW(FW)) u_div (
      .clk(clk), .adv(adv), .num(n0_r[f]), .den(dn0_r[f]),
      .side_in(f0_r[f]), .quo(tq[f]), .side_out(fside[f])
    );
    assign f1[f] = face_t'(fside[f]);
  end

  // Carry the point data alongside the divider through a delay line.
  localparam int PW = 3 * (CW + 1) * 2 + 3 * (CW + 2) + 1;
  logic [PW-1:0] pd_r [T_BITS+1];
  always_comb pd_r[0] = {v0_r, s0_r[0], s0_r[1], s0_r[2], e0_r[0], e0_r[1],
                         e0_r[2], d0_r[0], d0_r[1], d0_r[2]};
  for (genvar k = 0; k < T_BITS; k++) begin : g_dl
    always_ff @(posedge clk) begin
      if (!rst_n) pd_r[k+1][PW-1] <= 1'b0;
      else if (adv) pd_r[k+1][PW-1] <= pd_r[k][PW-1];
      if (adv) pd_r[k+1][PW-2:0] <= pd_r[k][PW-2:0];
    end
  end

  logic               v1;
  logic signed [CW:0]   s1 [3];
  logic signed [CW:0]   e1 [3];
  logic signed [CW+1:0] d1 [3];
  assign {v1, s1[0], s1[1], s1[2], e1[0], e1[1], e1[2], d1[0], d1[1], d1[2]}
    = pd_r[T_BITS];

  // ---------------- fold six faces in order: two stages --------------------
  // Stage A folds x and y faces, stage B folds z faces.
  function automatic void fold(input face_t fc, input logic [31:0] q,
                               inout logic ok, inout logic [T_BITS:0] t0,
                               inout logic [T_BITS:0] t1);
    logic [T_BITS:0] t;
    t = fc.one ? T_ONE : {1'b0, q};
    if (ok) begin
      if (fc.cat == C_REJ) ok = 1'b0;
      else if (fc.cat == C_DIV) begin
        if (fc.enter) begin
          if (t > t1) ok = 1'b0;
          else if (t > t0) t0 = t;
        end else begin
          if (t < t0) ok = 1'b0;
          else if (t < t1) t1 = t;
        end
      end
    end
  endfunction

  logic            va_r, oka_r;
  logic [T_BITS:0] t0a_r, t1a_r;
  face_t           fza_r [2];
  logic [31:0]     tza_r [2];
  logic signed [CW:0]   sa_r [3];
  logic signed [CW:0]   ea_r [3];
  logic signed [CW+1:0] da_r [3];

  always_ff @(posedge clk) begin
    logic ok;
    logic [T_BITS:0] t0, t1;
    ok = 1'b1; t0 = '0; t1 = T_ONE;
    for (int f = 0; f < 4; f++) fold(f1[f], tq[f], ok, t0, t1);
    if (!rst_n) va_r <= 1'b0;
    else if (adv) va_r <= v1;
    if (adv) begin
      oka_r <= ok; t0a_r <= t0; t1a_r <= t1;
      fza_r[0] <= f1[4]; fza_r[1] <= f1[5];
      tza_r[0] <= tq[4]; tza_r[1] <= tq[5];
      sa_r <= s1; ea_r <= e1; da_r <= d1;
    end
  end

  logic            vb_r, okb_r;
  logic [T_BITS:0] t0b_r, t1b_r;
  logic signed [CW:0]   sb_r [3];
  logic signed [CW:0]   eb_r [3];
  logic signed [CW+1:0] db_r [3];

  always_ff @(posedge clk) begin
    logic ok;
    logic [T_BITS:0] t0, t1;
    ok = oka_r; t0 = t0a_r; t1 = t1a_r;
    fold(fza_r[0], tza_r[0], ok, t0, t1);
    fold(fza_r[1], tza_r[1], ok, t0, t1);
    if (!rst_n) vb_r <= 1'b0;
    else if (adv) vb_r <= va_r;
    if (adv) begin
      okb_r <= ok; t0b_r <= t0; t1b_r <= t1;
      sb_r <= sa_r; eb_r <= ea_r; db_r <= da_r;
    end
  end

  // ---------------- multiply: |d| split in 32-bit halves -------------------
  // step = hi*t + ((lo*t + 2^31) >> 32); partial products registered here.
  localparam int HW = (CW + 2 > 32) ? CW + 2 - 32 : 1;
  logic            vc_r, okc_r, mv0_r, mv1_r;
  logic signed [CW:0]   sc_r [3];
  logic signed [CW:0]   ec_r [3];
  logic            neg_r [3];
  logic [HW+T_BITS:0] h0_r [3];
  logic [HW+T_BITS:0] h1_r [3];
  logic [64:0]        l0_r [3];
  logic [64:0]        l1_r [3];

  always_ff @(posedge clk) begin
    logic [CW+1:0] mag;
    logic [63:0]   mg;
    if (!rst_n) vc_r <= 1'b0;
    else if (adv) vc_r <= vb_r;
    if (adv) begin
      okc_r <= okb_r;
      mv0_r <= t0b_r != '0;
      mv1_r <= t1b_r != T_ONE;
      for (int a = 0; a < 3; a++) begin
        mag = db_r[a][CW+1] ? -db_r[a] : db_r[a];
        mg  = 64'(mag);
        neg_r[a] <= db_r[a][CW+1];
        h0_r[a] <= (HW+T_BITS+1)'(mg[63:32]) * (HW+T_BITS+1)'(t0b_r);
        h1_r[a] <= (HW+T_BITS+1)'(mg[63:32]) * (HW+T_BITS+1)'(t1b_r);
        l0_r[a] <= 65'(mg[31:0]) * 65'(t0b_r);
        l1_r[a] <= 65'(mg[31:0]) * 65'(t1b_r);
        sc_r[a] <= sb_r[a];
        ec_r[a] <= eb_r[a];
      end
    end
  end

  // ---------------- add, saturate, select ----------------------------------
  localparam int SWD = HW + T_BITS + 4;
  localparam logic signed [SWD-1:0] HI_S = SWD'((64'(1) << (CW - 1)) - 1);
  localparam logic signed [SWD-1:0] LO_S = -HI_S - 1;

  function automatic logic [CW-1:0] finish(input logic signed [CW:0] s,
                                           input logic neg,
                                           input logic [HW+T_BITS:0] h,
                                           input logic [64:0] l);
    logic [65:0] lr;
    logic signed [SWD-1:0] st, r;
    lr = 66'(l) + 66'(64'd1 << 31);
    st = SWD'(h) + SWD'(lr[65:32]);
    r  = neg ? SWD'(s) - st : SWD'(s) + st;
    if (r > HI_S) r = HI_S;
    if (r < LO_S) r = LO_S;
    return r[CW-1:0];
  endfunction

  logic          vis_r;
  logic [CW-1:0] cs_r [3];
  logic [CW-1:0] ce_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= vc_r;
    if (adv) begin
      vis_r <= okc_r;
      for (int a = 0; a < 3; a++) begin
        cs_r[a] <= (okc_r && mv0_r) ? finish(sc_r[a], neg_r[a], h0_r[a], l0_r[a])
                                    : sc_r[a][CW-1:0];
        ce_r[a] <= (okc_r && mv1_r) ? finish(sc_r[a], neg_r[a], h1_r[a], l1_r[a])
                                    : ec_r[a][CW-1:0];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_visible      = vis_r;
  assign out_clip_start_x = cs_r[0];
  assign out_clip_start_y = cs_r[1];
  assign out_clip_start_z = cs_r[2];
  assign out_clip_end_x   = ce_r[0];
  assign out_clip_end_y   = ce_r[1];
  assign out_clip_end_z   = ce_r[2];
endmodule
`default_nettype wire

### rtl/lcc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcc_div
// Pipelined restoring divider: one quotient bit per stage, T_BITS stages.
// Computes floor(num * 2^T_BITS / den) for 0 <= num < den.
// ----------------------------------------------------------------------------
module lcc_div #(
  parameter int DW = 34,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire logic [DW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic [31:0]        quo,
  output logic [SW-1:0]      side_out
);
  import lcc_pkg::*;

  logic [DW:0]     rem_r  [T_BITS+1];
  logic [DW-1:0]   den_r  [T_BITS+1];
  logic [T_BITS-1:0] q_r  [T_BITS+1];
  logic [SW-1:0]   side_r [T_BITS+1];

  always_comb begin
    rem_r[0]  = {1'b0, num};
    den_r[0]  = den;
    q_r[0]    = '0;
    side_r[0] = side_in;
  end

  for (genvar k = 0; k < T_BITS; k++) begin : g_st
    logic [DW:0] sh;
    logic        ge;
    assign sh = {rem_r[k][DW-1:0], 1'b0};
    assign ge = sh >= {1'b0, den_r[k]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1]  <= ge ? sh - {1'b0, den_r[k]} : sh;
        den_r[k+1]  <= den_r[k];
        q_r[k+1]    <= {q_r[k][T_BITS-2:0], ge};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign quo      = q_r[T_BITS];
  assign side_out = side_r[T_BITS];
endmodule
`default_nettype wire

### bench/tb_line_clip_unit_cube.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_clip_unit_cube
// Self-checking bench for the unit cube segment clipper.
// ----------------------------------------------------------------------------
// Segments are queued by an initial block and driven one beat at a time.
// Every accepted segment is clipped by a fixed-point predictor in the bench
// and the expected beat is queued. A monitor compares each output beat, field
// by field, with the oldest expected one. Both sides idle at random, and a
// long receiver hold-off fills the pipe and backs up the input.
// ----------------------------------------------------------------------------
module tb_line_clip_unit_cube;
  import lcc_pkg::*;

  localparam int      CW      = COORD_WIDTH_DEF;
  localparam longint  UNIT    = longint'(1) << FRAC_BITS;
  localparam bit [63:0] T_FULL = 64'd1 << T_BITS;
  localparam int      N_RAND  = 1600;
  localparam int      LIMIT   = 200000;

  typedef struct packed {
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
  } seg_t;

  typedef struct packed {
    logic                 vis;
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
  } clip_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  seg_t in_seg = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  clip_t out_beat;

  seg_t  seg_q[$];
  clip_t clip_q[$];
  bit    feed_done = 1'b0;
  int    cycle = 0;
  int    hold_cnt = 0;
  int    n_fail = 0;
  int    n_vis = 0;
  int    n_rej = 0;
  int    n_seen = 0;

  always #1 clk = ~clk;

  line_clip_unit_cube u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_x      (in_seg.sx),
    .in_start_y      (in_seg.sy),
    .in_start_z      (in_seg.sz),
    .in_end_x        (in_seg.ex),
    .in_end_y        (in_seg.ey),
    .in_end_z        (in_seg.ez),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_visible     (out_beat.vis),
    .out_clip_start_x(out_beat.sx),
    .out_clip_start_y(out_beat.sy),
    .out_clip_start_z(out_beat.sz),
    .out_clip_end_x  (out_beat.ex),
    .out_clip_end_y  (out_beat.ey),
    .out_clip_end_z  (out_beat.ez)
  );

  // num / den with T_BITS fraction bits, truncated; 0 <= num, den > 0
  function automatic bit [63:0] frac_div(bit [63:0] num, bit [63:0] den);
    bit [63:0] r;
    bit [63:0] t;
    r = num;
    t = 0;
    if (num >= den) return T_FULL;
    for (int i = 0; i < T_BITS; i++) begin
      r = r << 1;
      t = t << 1;
      if (r >= den) begin
        r = r - den;
        t[0] = 1'b1;
      end
    end
    return t;
  endfunction

  // s + t * d, product rounded half away from zero, sum saturated
  function automatic logic signed [CW-1:0] move_along(longint s, longint d, bit [63:0] t);
    bit [63:0] mag;
    bit [63:0] prod;
    longint    v;
    mag  = (d < 0) ? 64'(-d) : 64'(d);
    prod = (mag >> 32) * t + (((mag & 64'hFFFF_FFFF) * t + (64'd1 << 31)) >> 32);
    v    = (d < 0) ? s - longint'(prod) : s + longint'(prod);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[CW-1:0];
  endfunction

  function automatic clip_t clip_segment(seg_t g);
    longint    sp[3];
    longint    ep[3];
    longint    dv[3];
    longint    p, q;
    bit [63:0] t0, t1, tt;
    bit        pass;
    int        ax;
    clip_t     r;
    sp[0] = longint'(g.sx); sp[1] = longint'(g.sy); sp[2] = longint'(g.sz);
    ep[0] = longint'(g.ex); ep[1] = longint'(g.ey); ep[2] = longint'(g.ez);
    for (int i = 0; i < 3; i++) dv[i] = ep[i] - sp[i];
    t0 = 0;
    t1 = T_FULL;
    pass = 1'b1;
    for (int i = 0; i < 6 && pass; i++) begin
      ax = i / 2;
      if (i % 2 == 0) begin
        p = dv[ax];
        q = -UNIT - sp[ax];
      end else begin
        p = -dv[ax];
        q = sp[ax] - UNIT;
      end
      if (p > 0) begin
        if (q > 0) begin
          if (q > p) pass = 1'b0;
          else begin
            tt = frac_div(64'(q), 64'(p));
            if (tt > t1) pass = 1'b0;
            else if (tt > t0) t0 = tt;
          end
        end
      end else if (p < 0) begin
        // exit test: t = (-q) / (-p)
        if (-q < 0) pass = 1'b0;
        else if (-q <= -p) begin
          tt = frac_div(64'(-q), 64'(-p));
          if (tt < t0) pass = 1'b0;
          else if (tt < t1) t1 = tt;
        end
      end else if (q > 0) begin
        pass = 1'b0;
      end
    end
    r.vis = pass;
    r.sx = g.sx; r.sy = g.sy; r.sz = g.sz;
    r.ex = g.ex; r.ey = g.ey; r.ez = g.ez;
    if (pass) begin
      if (t1 < T_FULL) begin
        r.ex = move_along(sp[0], dv[0], t1);
        r.ey = move_along(sp[1], dv[1], t1);
        r.ez = move_along(sp[2], dv[2], t1);
      end
      if (t0 > 0) begin
        r.sx = move_along(sp[0], dv[0], t0);
        r.sy = move_along(sp[1], dv[1], t0);
        r.sz = move_along(sp[2], dv[2], t0);
      end
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(int mode);
    int k;
    k = $urandom_range(0, 15);
    if (mode == 0) return $urandom;
    if (k == 0) return CW'(UNIT);
    if (k == 1) return CW'(-UNIT);
    if (k == 2) return 0;
    if (mode == 1) return int'($urandom_range(0, 2 * 65536 + 1)) - 65536;
    return int'($urandom_range(0, 6 * 65536)) - 3 * 65536;
  endfunction

  function automatic seg_t pick_segment();
    seg_t g;
    int   mode;
    mode = $urandom_range(0, 9);
    g.sx = pick_coord(mode == 0 ? 0 : 2);
    g.sy = pick_coord(mode == 0 ? 0 : 2);
    g.sz = pick_coord(mode == 0 ? 0 : 2);
    g.ex = pick_coord(mode == 0 ? 0 : (mode == 3 ? 1 : 2));
    g.ey = pick_coord(mode == 0 ? 0 : (mode == 3 ? 1 : 2));
    g.ez = pick_coord(mode == 0 ? 0 : (mode == 3 ? 1 : 2));
    if (mode == 1) begin
      g.ex = g.sx; g.ey = g.sy; g.ez = g.sz;
    end else if (mode == 2) begin
      // flatten one or two axes to get parallel tests
      g.ex = g.sx;
      if ($urandom_range(0, 1)) g.ey = g.sy;
    end
    return g;
  endfunction

  // append a segment to the pending stimulus
  function automatic void queue_seg(seg_t g);
    seg_q.insert(seg_q.size(), g);
  endfunction

  // in_stall as seen at the last rising edge
  logic in_stall_q = 1'b0;
  always @(posedge clk) in_stall_q <= in_stall;

  // Driver: hold a beat until accepted, idle at random between beats
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (cycle > 1500 && cycle < 2500) ? 0 : 30;
    if (rst_n && (!in_valid || !in_stall_q)) begin
      if (seg_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_seg   <= seg_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off counted down here
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else if (cycle == 800) begin
      out_stall <= 1'b1;
      hold_cnt  <= 299;
    end else if (cycle > 1500 && cycle < 2500) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 30);
  end

  // Predict on each accepted input beat, check each accepted output beat
  always @(posedge clk) begin
    clip_t want;
    cycle <= cycle + 1;
    if (rst_n && in_valid && !in_stall) clip_q.insert(clip_q.size(), clip_segment(in_seg));
    if (rst_n && out_valid && !out_stall) begin
      if (clip_q.size() == 0) begin
        $error("output beat with nothing expected");
        n_fail++;
      end else begin
        want = clip_q.pop_front();
        n_seen++;
        if (want.vis) n_vis++; else n_rej++;
        if (out_beat.vis !== want.vis) begin
          $error("visible exp %0d got %0d", want.vis, out_beat.vis); n_fail++;
        end
        if (out_beat.sx !== want.sx) begin
          $error("clip_start_x exp %0d got %0d", want.sx, out_beat.sx); n_fail++;
        end
        if (out_beat.sy !== want.sy) begin
          $error("clip_start_y exp %0d got %0d", want.sy, out_beat.sy); n_fail++;
        end
        if (out_beat.sz !== want.sz) begin
          $error("clip_start_z exp %0d got %0d", want.sz, out_beat.sz); n_fail++;
        end
        if (out_beat.ex !== want.ex) begin
          $error("clip_end_x exp %0d got %0d", want.ex, out_beat.ex); n_fail++;
        end
        if (out_beat.ey !== want.ey) begin
          $error("clip_end_y exp %0d got %0d", want.ey, out_beat.ey); n_fail++;
        end
        if (out_beat.ez !== want.ez) begin
          $error("clip_end_z exp %0d got %0d", want.ez, out_beat.ez); n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle >= LIMIT) begin
      $display("line_clip_unit_cube regression: fail");
      $finish;
    end
  end

  function automatic seg_t mk(longint a, longint b, longint c, longint d, longint e, longint f);
    seg_t g;
    g.sx = a[CW-1:0]; g.sy = b[CW-1:0]; g.sz = c[CW-1:0];
    g.ex = d[CW-1:0]; g.ey = e[CW-1:0]; g.ez = f[CW-1:0];
    return g;
  endfunction

  initial begin
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    // directed: extremes, crossings, parallel and degenerate cases
    queue_seg(mk(0, 0, 0, 0, 0, 0));
    queue_seg(mk(UNIT, -UNIT, UNIT, UNIT, -UNIT, UNIT));
    queue_seg(mk(2 * UNIT, 0, 0, 2 * UNIT, 0, 0));
    queue_seg(mk(-2 * UNIT, 0, 0, 2 * UNIT, 0, 0));
    queue_seg(mk(0, 2 * UNIT, 0, 0, -2 * UNIT, 0));
    queue_seg(mk(0, 0, -3 * UNIT, 0, 0, 3 * UNIT));
    queue_seg(mk(-3 * UNIT, -3 * UNIT, -3 * UNIT, 3 * UNIT, 3 * UNIT, 3 * UNIT));
    queue_seg(mk(2 * UNIT, 2 * UNIT, 0, 3 * UNIT, 3 * UNIT, 0));
    queue_seg(mk(-2 * UNIT, 0, 0, -3 * UNIT, 0, 0));
    queue_seg(mk(0, 0, 0, 5 * UNIT, 0, 0));
    queue_seg(mk(5 * UNIT, 0, 0, 0, 0, 0));
    queue_seg(mk(2 * UNIT, 0, 0, 0, 2 * UNIT, 0));
    queue_seg(mk(UNIT + UNIT / 2, 0, 0, 0, UNIT + UNIT / 2, 0));
    queue_seg(mk(mn, mn, mn, mx, mx, mx));
    queue_seg(mk(mx, mx, mx, mn, mn, mn));
    queue_seg(mk(mn, 0, 0, mx, 0, 0));
    queue_seg(mk(mx, mx, mx, mx, mx, mx));
    queue_seg(mk(mn, mn, mn, mn, mn, mn));
    queue_seg(mk(-UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT));
    queue_seg(mk(0, UNIT + 1, 0, 0, UNIT + 1, 1));
    queue_seg(mk(-UNIT - 1, 0, 0, UNIT + 1, 1, -1));
    for (int i = 0; i < N_RAND; i++) queue_seg(pick_segment());
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (seg_q.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (clip_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("checked %0d clipped segments: %0d visible, %0d rejected", n_seen, n_vis, n_rej);
    $display("stimulus: corner, parallel, degenerate and random segments, with stalls");
    if (n_fail == 0) begin
      $display("line_clip_unit_cube regression: pass");
    end else begin
      $display("line_clip_unit_cube regression: fail");
    end
    $finish;
  end

endmodule
